### rtl/core/oaht_pkg.sv
// Package for the open-address hash table: payload structs, slot tag layout,
// operation, slot-kind and status codes. No dependencies.
package oaht_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned HASH_W  = 32;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned FILL_W  = 9;

   localparam logic [FILL_W-1:0] MAX_FILL_RESET = 9'd192;

   // Operation codes.
   localparam logic [1:0] OP_GET    = 2'd0;
   localparam logic [1:0] OP_SET    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Slot kinds.
   localparam logic [1:0] KIND_EMPTY = 2'd0;
   localparam logic [1:0] KIND_USED  = 2'd1;
   localparam logic [1:0] KIND_TOMB  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_MISSING = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [KEY_W-1:0]   key_id;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               was_new;
      logic [VALUE_W-1:0] read_value;
   } rsp_type;

   // One slot's kind and key, stored together in the tag memory.
   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
   } tag_type;

   typedef struct packed {
      logic tag_en;
      logic value_en;
   } mem_wr_type;

   typedef struct packed {
      logic is_empty;
      logic is_tomb;
      logic is_hit;
      logic is_last;
   } verdict_type;

endpackage

### rtl/core/oaht_store.sv
// Slot storage: a tag memory (kind and key) and a value memory, one shared
// write port and one registered read port. Depends on oaht_pkg.
module oaht_store #(
   parameter int unsigned ADDR_W = 8
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output oaht_pkg::tag_type           rd_tag,
   output logic [oaht_pkg::VALUE_W-1:0] rd_value,
   input  oaht_pkg::mem_wr_type        wr,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  oaht_pkg::tag_type           wr_tag,
   input  logic [oaht_pkg::VALUE_W-1:0] wr_value
);
   import oaht_pkg::*;

   localparam int unsigned DEPTH = 1 << ADDR_W;

   tag_type            tag_mem   [DEPTH];
   logic [VALUE_W-1:0] value_mem [DEPTH];
   tag_type            tag_q_ff;
   logic [VALUE_W-1:0] value_q_ff;

   always_ff @(posedge clock) begin
      if (wr.tag_en) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (wr.value_en) begin
         value_mem[wr_addr] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         tag_q_ff   <= tag_mem[rd_addr];
         value_q_ff <= value_mem[rd_addr];
      end
   end

   assign rd_tag   = tag_q_ff;
   assign rd_value = value_q_ff;

endmodule

### rtl/core/oaht_probe.sv
// Probe unit: classifies one slot against the search key and steps the
// probe index with wrap. Depends on oaht_pkg.
module oaht_probe #(
   parameter int unsigned ADDR_W = 8
) (
   input  oaht_pkg::tag_type          tag,
   input  logic [oaht_pkg::KEY_W-1:0] key,
   input  logic [ADDR_W-1:0]          idx,
   input  logic [ADDR_W-1:0]          count,
   output oaht_pkg::verdict_type      verdict,
   output logic [ADDR_W-1:0]          next_idx
);
   import oaht_pkg::*;

   always_comb begin
      verdict.is_empty = (tag.kind == KIND_EMPTY);
      verdict.is_tomb  = (tag.kind == KIND_TOMB);
      verdict.is_hit   = (tag.kind == KIND_USED) && (tag.key == key);
      // The last slot of a full lap has been reached.
      verdict.is_last  = (count == {ADDR_W{1'b1}});
   end

   // Wrap comes for free from the index width.
   assign next_idx = idx + {{(ADDR_W-1){1'b0}}, 1'b1};

endmodule

### rtl/core/open_address_hash_table.sv
// Top level of the open-address hash table: sequencer, fill count, limit
// register and result register. Uses oaht_pkg, oaht_store and oaht_probe.
//
//  Port group   Direction  Handshake          Carries
//  req_*        in         req_valid/ready    req_type word: opcode, key, hash, value
//  rsp_*        out        rsp_valid/ready    rsp_type word: status, was_new, value
//  csr_*        in         csr_wr_en only     max_fill limit, 9 bits
//
// After reset the block sweeps the tag memory, one slot a cycle, and holds
// req_ready low meanwhile; csr writes are taken throughout.
// Each probed slot passes through a memory read, then a check in the probe
// unit; an item then passes the done state into the result register, and
// an unused opcode goes straight from accept to the done state.
// One item is worked on at a time. A finished word sits in the rsp register,
// and the next request word can be accepted and probed while it waits.
module open_address_hash_table #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  oaht_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output oaht_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [oaht_pkg::FILL_W-1:0]  csr_wr_data
);
   import oaht_pkg::*;

   localparam int unsigned ADDR_W = $clog2(CAPACITY);

   // Sequencer states.
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_idx_ff, clr_idx_in;
   req_type            req_ff, req_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   logic               empty_ff, empty_in;
   logic               tomb_seen_ff, tomb_seen_in;
   logic [ADDR_W-1:0]  tomb_idx_ff, tomb_idx_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  max_fill_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   tag_type            rd_tag;
   logic [VALUE_W-1:0] rd_value;
   mem_wr_type         wr;
   logic [ADDR_W-1:0]  wr_addr;
   tag_type            wr_tag;
   logic [VALUE_W-1:0] wr_value;
   verdict_type        verdict;
   logic [ADDR_W-1:0]  next_idx;
   logic               done_go;
   logic               fill_ok;

   oaht_store #(.ADDR_W(ADDR_W)) u_store (
      .clock    (clock),
      .rd_en    (state_ff == S_READ),
      .rd_addr  (idx_ff),
      .rd_tag   (rd_tag),
      .rd_value (rd_value),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_value (wr_value)
   );

   oaht_probe #(.ADDR_W(ADDR_W)) u_probe (
      .tag      (rd_tag),
      .key      (req_ff.key_id),
      .idx      (idx_ff),
      .count    (cnt_ff),
      .verdict  (verdict),
      .next_idx (next_idx)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The finished word may only be loaded once the result slot is free.
   assign done_go = !rsp_valid_ff || rsp_ready;
   // A fresh insert is allowed while the fill count stays within the limit.
   assign fill_ok = (({1'b0, fill_ff} + {{FILL_W{1'b0}}, 1'b1}) <= {1'b0, max_fill_ff});

   function automatic logic [ADDR_W-1:0] next_idx_clear(input logic [ADDR_W-1:0] idx);
      next_idx_clear = idx + {{(ADDR_W-1){1'b0}}, 1'b1};
   endfunction

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      empty_in     = empty_ff;
      tomb_seen_in = tomb_seen_ff;
      tomb_idx_in  = tomb_idx_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr           = '0;
      wr_addr      = idx_ff;
      wr_tag       = '{kind: KIND_USED, key: req_ff.key_id};
      wr_value     = req_ff.new_value;

      unique case (state_ff)
         S_CLEAR: begin
            // Sweep every slot to empty after reset.
            wr.tag_en  = 1'b1;
            wr_addr    = clr_idx_ff;
            wr_tag     = '{kind: KIND_EMPTY, key: '0};
            clr_idx_in = next_idx_clear(clr_idx_ff);
            if (clr_idx_ff == {ADDR_W{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               idx_in       = req_data.key_hash[ADDR_W-1:0];
               cnt_in       = '0;
               hit_in       = 1'b0;
               empty_in     = 1'b0;
               tomb_seen_in = 1'b0;
               state_in     = (req_data.opcode == OP_UNUSED) ? S_DONE : S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (verdict.is_empty) begin
               empty_in = 1'b1;
               state_in = S_DONE;
            end else if (verdict.is_hit) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               if (verdict.is_tomb && !tomb_seen_ff) begin
                  tomb_seen_in = 1'b1;
                  tomb_idx_in  = idx_ff;
               end
               if (verdict.is_last) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = next_idx;
                  cnt_in   = cnt_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
                  state_in = S_READ;
               end
            end
         end
         S_DONE: begin
            if (done_go) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: STATUS_MISSING, was_new: 1'b0, read_value: '0};
               state_in     = S_IDLE;
               case (req_ff.opcode)
                  OP_GET: begin
                     if (hit_ff) begin
                        rsp_in.status     = STATUS_OK;
                        rsp_in.read_value = rd_value;
                     end
                  end
                  OP_SET: begin
                     if (hit_ff) begin
                        wr.value_en   = 1'b1;
                        rsp_in.status = STATUS_OK;
                     end else if (tomb_seen_ff) begin
                        wr.tag_en      = 1'b1;
                        wr.value_en    = 1'b1;
                        wr_addr        = tomb_idx_ff;
                        rsp_in.status  = STATUS_OK;
                        rsp_in.was_new = 1'b1;
                     end else if (empty_ff && fill_ok) begin
                        wr.tag_en      = 1'b1;
                        wr.value_en    = 1'b1;
                        fill_in        = fill_ff + {{(FILL_W-1){1'b0}}, 1'b1};
                        rsp_in.status  = STATUS_OK;
                        rsp_in.was_new = 1'b1;
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  OP_DELETE: begin
                     if (hit_ff) begin
                        // The key stays in place under the tombstone.
                        wr.tag_en     = 1'b1;
                        wr_tag.kind   = KIND_TOMB;
                        rsp_in.status = STATUS_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         fill_ff      <= '0;
         max_fill_ff  <= MAX_FILL_RESET;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         tomb_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         tomb_seen_ff <= tomb_seen_in;
         if (csr_wr_en) begin
            max_fill_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      cnt_ff      <= cnt_in;
      tomb_idx_ff <= tomb_idx_in;
      rsp_ff      <= rsp_in;
   end

   // A completed item always lands in the result register on the next cycle.
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && done_go |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished item did not reach the result register");

   // The memories are only written by the clearing sweep or at item completion.
   a_write_only_when_allowed: assert property (@(posedge clock) disable iff (reset)
      (wr.tag_en || wr.value_en) |-> (state_ff == S_CLEAR) || ((state_ff == S_DONE) && done_go))
      else $error("slot memory written outside clearing or completion");

   // A full (rejected) result never reports a new key and carries a zero value.
   a_full_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == STATUS_FULL) |-> !rsp_ff.was_new && (rsp_ff.read_value == '0))
      else $error("full status with stray fields");

   // The fill count only changes at item completion, where an insert into an empty slot raises it by one.
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_DONE) |=> $stable(fill_ff))
      else $error("fill count changed outside completion");

endmodule

### test/oaht_checker.sv
// Scoreboard for the open-address hash table: a slot-level model of the map,
// a queue of predicted answers and a field-by-field comparison of each result.
// Depends on oaht_pkg for the payload types and the code constants.
module oaht_checker #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  oaht_pkg::req_type           req_data,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  oaht_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [oaht_pkg::FILL_W-1:0] csr_wr_data,
   output int                          mismatch_count,
   output int                          answers_owed
);
   import oaht_pkg::*;

   localparam int MAX_REPORTS = 10;

   logic [1:0]         model_kind  [CAPACITY];
   logic [KEY_W-1:0]   model_key   [CAPACITY];
   logic [VALUE_W-1:0] model_value [CAPACITY];
   int unsigned        model_fill;
   logic [FILL_W-1:0]  model_limit;
   rsp_type            owed_answers [$];
   int unsigned        answers_seen;

   // Applies one operation to the model and returns the answer it must give.
   function automatic rsp_type predict_map_access(input req_type w);
      int          hit;
      int          first_tomb;
      int          first_empty;
      int unsigned idx;
      bit          done;
      rsp_type     r;
      r.status     = STATUS_MISSING;
      r.was_new    = 1'b0;
      r.read_value = '0;
      if (w.opcode == OP_UNUSED) begin
         return r;
      end
      hit         = -1;
      first_tomb  = -1;
      first_empty = -1;
      done        = 1'b0;
      idx         = w.key_hash % CAPACITY;
      for (int n = 0; n < CAPACITY && !done; n++) begin
         if (model_kind[idx] == KIND_EMPTY) begin
            first_empty = idx;
            done = 1'b1;
         end else if (model_kind[idx] == KIND_TOMB) begin
            if (first_tomb < 0) first_tomb = idx;
         end else if (model_key[idx] == w.key_id) begin
            hit = idx;
            done = 1'b1;
         end
         idx = (idx + 1) % CAPACITY;
      end
      case (w.opcode)
         OP_GET: begin
            if (hit >= 0) begin
               r.status     = STATUS_OK;
               r.read_value = model_value[hit];
            end
         end
         OP_SET: begin
            if (hit >= 0) begin
               model_value[hit] = w.new_value;
               r.status = STATUS_OK;
            end else if (first_tomb >= 0) begin
               model_kind[first_tomb]  = KIND_USED;
               model_key[first_tomb]   = w.key_id;
               model_value[first_tomb] = w.new_value;
               r.status  = STATUS_OK;
               r.was_new = 1'b1;
            end else if (first_empty >= 0 && model_fill + 1 <= model_limit) begin
               model_kind[first_empty]  = KIND_USED;
               model_key[first_empty]   = w.key_id;
               model_value[first_empty] = w.new_value;
               model_fill++;
               r.status  = STATUS_OK;
               r.was_new = 1'b1;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               model_kind[hit] = KIND_TOMB;
               r.status = STATUS_OK;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : track_and_compare
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < CAPACITY; i++) model_kind[i] = KIND_EMPTY;
         model_fill     = 0;
         model_limit    = MAX_FILL_RESET;
         answers_seen   = 0;
         mismatch_count = 0;
         owed_answers.delete();
      end else begin
         if (csr_wr_en) model_limit = csr_wr_data;
         if (req_valid && req_ready) owed_answers.push_back(predict_map_access(req_data));
         if (rsp_valid && rsp_ready) begin
            if (owed_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result word %0d arrived with nothing owed: status %0d was_new %0b value %h",
                           answers_seen, rsp_data.status, rsp_data.was_new,
                           rsp_data.read_value);
            end else begin
               want = owed_answers.pop_front();
               if (rsp_data.status !== want.status || rsp_data.was_new !== want.was_new ||
                   rsp_data.read_value !== want.read_value) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("result word %0d: expected status %0d was_new %0b value %h, got status %0d was_new %0b value %h",
                              answers_seen, want.status, want.was_new, want.read_value,
                              rsp_data.status, rsp_data.was_new, rsp_data.read_value);
               end
            end
            answers_seen++;
         end
      end
      answers_owed <= owed_answers.size();
   end

endmodule

### test/testbench.sv
// Top of the hash table bench: clock, reset, request and result drivers,
// limit register writes, watchdog and verdict. Depends on oaht_pkg, the
// block open_address_hash_table and the scoreboard oaht_checker.
module testbench;
   import oaht_pkg::*;

   localparam int unsigned CAPACITY    = 256;
   // The longest quiet stretch of a correct run is a probe over the whole
   // table or the long result hold-off below.
   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned PCT_IDLE    = 11;
   localparam int unsigned POOL_DEPTH  = 512;
   localparam int unsigned HOLD_AT     = 300;
   localparam int unsigned HOLD_CYCLES = 400;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   req_type           req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [FILL_W-1:0] csr_wr_data = '0;

   int                mismatch_count;
   int                answers_owed;
   int unsigned       words_sent;
   int unsigned       quiet_cycles;

   // Keys that have been offered for insertion, with the hash that belongs
   // to each, so that later words can find, update and delete them.
   logic [KEY_W-1:0]  known_key  [POOL_DEPTH];
   logic [HASH_W-1:0] known_hash [POOL_DEPTH];
   int unsigned       known_count;

   open_address_hash_table #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   oaht_checker #(
      .CAPACITY(CAPACITY)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .mismatch_count(mismatch_count),
      .answers_owed  (answers_owed)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The watchdog ends the run when no word has moved on either channel for
   // too long, which covers a hung block as well as a lost result.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result side. The ready line drops on about 11 percent of cycles, except in
   // a window of steady acceptance. Once, after a few hundred results, it is
   // held low for a long stretch so that the result register and the probe
   // stage both fill and the block has to refuse further request words.
   initial begin : result_side
      int unsigned taken;
      int unsigned hold_left;
      bit          held_once;
      taken     = 0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!held_once && taken >= HOLD_AT) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (taken >= 600 && taken < 800) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= PCT_IDLE);
         end
      end
   end

   function automatic req_type compose_request(input logic [1:0] op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [HASH_W-1:0] hash,
                                               input logic [VALUE_W-1:0] value);
      req_type w;
      w.opcode    = op;
      w.key_id    = key;
      w.key_hash  = hash;
      w.new_value = value;
      return w;
   endfunction

   // Most hashes land in two narrow bands of home slots, one of them at the
   // top of the table, so that chains grow long and wrap past the last slot.
   // The upper bits stay random; only the low byte picks the home slot.
   function automatic logic [HASH_W-1:0] clustered_hash();
      logic [31:0] upper;
      logic [7:0]  home;
      upper = $urandom;
      case ($urandom_range(0, 3))
         0, 1:    home = 8'($urandom_range(0, 15));
         2:       home = 8'($urandom_range(240, 255));
         default: home = 8'($urandom);
      endcase
      return {upper[HASH_W-1:8], home};
   endfunction

   // A brand-new key with its hash, remembered for later words.
   task automatic fresh_key(output logic [KEY_W-1:0] key, output logic [HASH_W-1:0] hash);
      int unsigned slot;
      key  = $urandom;
      hash = clustered_hash();
      if (known_count < POOL_DEPTH) begin
         slot = known_count;
         known_count++;
      end else begin
         slot = $urandom_range(0, POOL_DEPTH - 1);
      end
      known_key[slot]  = key;
      known_hash[slot] = hash;
   endtask

   // Offers one request word and returns at the edge where it is taken.
   // Valid stays high into the next word when no idle cycle is drawn.
   task automatic send_word(input req_type w);
      if (words_sent < 600 || words_sent >= 800) begin
         while ($urandom_range(0, 99) < PCT_IDLE) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // The limit register is only written with the block idle: every owed
   // answer has come back, plus a short pause for good measure.
   task automatic set_fill_limit(input logic [FILL_W-1:0] limit);
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: sets often take new keys so the fill count keeps growing,
   // gets and deletes mostly aim at known keys, and a share of the words are
   // noise (unknown keys, known keys under a wrong hash, the unused opcode).
   task automatic mixed_traffic(input int unsigned count);
      logic [KEY_W-1:0]   key;
      logic [HASH_W-1:0]  hash;
      logic [1:0]         op;
      int unsigned        roll;
      int unsigned        pick;
      for (int unsigned i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 5)       op = OP_UNUSED;
         else if (roll < 40) op = OP_GET;
         else if (roll < 80) op = OP_SET;
         else                op = OP_DELETE;
         roll = $urandom_range(0, 99);
         if (known_count == 0 || (op == OP_SET && roll < 45)) begin
            fresh_key(key, hash);
         end else if (roll >= 95) begin
            key  = $urandom;
            hash = clustered_hash();
         end else begin
            pick = $urandom_range(0, known_count - 1);
            key  = known_key[pick];
            hash = (roll >= 90) ? clustered_hash() : known_hash[pick];
         end
         send_word(compose_request(op, key, hash, {$urandom, $urandom}));
      end
   endtask

   // A run of inserts with new keys, enough to use up every empty slot, so
   // that later probes walk the whole table without meeting an empty slot.
   task automatic insert_burst(input int unsigned count);
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      for (int unsigned i = 0; i < count; i++) begin
         fresh_key(key, hash);
         send_word(compose_request(OP_SET, key, hash, {$urandom, $urandom}));
      end
   endtask

   initial begin : stimulus
      known_count = 0;
      words_sent  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the limit at its reset value. A lookup in the
      // empty table, then field extremes in the first and last slot, a chain
      // that wraps from the last slot to the first, an update, deletes that
      // hit and miss, a probe that passes a tombstone, the unused opcode and
      // reuse of a tombstone by a new key.
      send_word(compose_request(OP_GET,    32'h0000_0000, 32'h0000_0000, 64'h0));
      send_word(compose_request(OP_SET,    32'h0000_0000, 32'h0000_0000, 64'h0));
      send_word(compose_request(OP_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
      send_word(compose_request(OP_SET,    32'h0000_1234, 32'h0000_00FF,
                                64'h0123_4567_89AB_CDEF));
      send_word(compose_request(OP_GET,    32'h0000_1234, 32'h0000_00FF, '1));
      send_word(compose_request(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
      send_word(compose_request(OP_SET,    32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                64'h5555_5555_AAAA_AAAA));
      send_word(compose_request(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
      send_word(compose_request(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
      send_word(compose_request(OP_GET,    32'h0000_1234, 32'h0000_00FF, 64'h0));
      send_word(compose_request(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
      send_word(compose_request(OP_GET,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0));
      send_word(compose_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
      send_word(compose_request(OP_GET,    32'h0000_0000, 32'h0000_0000, 64'h0));
      send_word(compose_request(OP_SET,    32'h0000_CAFE, 32'h8000_00FF,
                                64'hFEDC_BA98_7654_3210));
      send_word(compose_request(OP_GET,    32'h0000_CAFE, 32'h8000_00FF, 64'h0));
      send_word(compose_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000, 64'h0));

      // With a limit of zero a new key is refused when it would take an
      // empty slot, yet may still take the tombstone left in slot zero.
      // Updates of present keys are not affected by the limit.
      set_fill_limit('0);
      send_word(compose_request(OP_SET,    32'h0000_BEEF, 32'h0000_0010, 64'h1));
      send_word(compose_request(OP_SET,    32'h0000_BEEF, 32'h0000_0000, 64'h2));
      send_word(compose_request(OP_GET,    32'h0000_BEEF, 32'h0000_0000, 64'h0));
      send_word(compose_request(OP_SET,    32'h0000_1234, 32'h0000_00FF, 64'h3));
      send_word(compose_request(OP_GET,    32'h0000_BEEF, 32'h0000_0010, 64'h0));

      // Random phases. The fill count never drops, so the limits mostly
      // rise: a small one that is soon reached, a limit of one, a
      // middle one, one equal to the slot count, one far above it with a
      // burst of inserts that leaves no empty slot, and a random one.
      set_fill_limit(9'd24);
      mixed_traffic(150);
      set_fill_limit(9'd1);
      mixed_traffic(80);
      set_fill_limit(9'd100);
      mixed_traffic(180);
      set_fill_limit(9'd256);
      mixed_traffic(180);
      set_fill_limit(9'd511);
      insert_burst(260);
      mixed_traffic(150);
      set_fill_limit(FILL_W'($urandom_range(1, 511)));
      mixed_traffic(100);

      // Drain, then give any stray result word time to show up.
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && answers_owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/oaht_pkg.sv
rtl/core/oaht_store.sv
rtl/core/oaht_probe.sv
rtl/core/open_address_hash_table.sv
test/oaht_checker.sv
test/testbench.sv
